// ----- src/sorted_timestamp_window_queue_unit_macros.svh -----
// assertion macros for the timestamp window queue
`ifndef SORTED_TIMESTAMP_WINDOW_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMESTAMP_WINDOW_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define STWQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stwq check failed");

// next-cycle implication
`define STWQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stwq check failed");

`endif

// ----- src/stwq_pkg.sv -----
package stwq_pkg;

  localparam int STAMP_W     = 63;
  localparam int GAP_W       = 32;
  localparam int LIMIT_W     = 5;
  localparam int ACTION_W    = 2;
  localparam int SCENE_W     = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_SCENE_COUNT = 4;
  localparam int DEF_LIST_DEPTH  = 16;

  localparam logic [GAP_W-1:0]   GAP_RESET   = 32'd1000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_FRAME     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_ONE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_WR
  } state_t;

  typedef struct packed {
    logic accept;
    logic cmp;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic frame_in;
  } sts_t;

endpackage

// ----- src/sorted_timestamp_window_queue_unit.sv -----
// channel   dir  handshake            beat
// in_       in   in_valid/in_ready    in_action, in_scene, in_stamp_ms
// out_      out  out_valid/out_ready  out_list_count, out_purged, out_duplicate
// cfg_      in   cfg_we               cfg_index, cfg_data
//
// frame beat: accept, then row read and compare, then insert and write back
// clear and other beats: accept, then write back; no row read
// at most one scene row is read and written per frame beat through a simple dual-port row memory
// reset: synchronous, active low; counts cleared at once, no memory sweep
// a held result stalls the write-back state; no new beat is taken meanwhile
module sorted_timestamp_window_queue_unit #(
  parameter int SCENE_COUNT = stwq_pkg::DEF_SCENE_COUNT,
  parameter int LIST_DEPTH  = stwq_pkg::DEF_LIST_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [stwq_pkg::ACTION_W-1:0]    in_action,
  input  logic [stwq_pkg::SCENE_W-1:0]     in_scene,
  input  logic [stwq_pkg::STAMP_W-1:0]     in_stamp_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [stwq_pkg::COUNT_OUT_W-1:0] out_list_count,
  output logic                             out_purged,
  output logic                             out_duplicate,
  input  logic                             cfg_we,
  input  logic [stwq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stwq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import stwq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stwq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stwq_dp #(
    .SCENE_COUNT (SCENE_COUNT),
    .LIST_DEPTH  (LIST_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_scene       (in_scene),
    .in_stamp_ms    (in_stamp_ms),
    .out_list_count (out_list_count),
    .out_purged     (out_purged),
    .out_duplicate  (out_duplicate),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ----- src/stwq_ram.sv -----
module stwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/stwq_ctrl.sv -----
module stwq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  stwq_pkg::sts_t sts,
  output stwq_pkg::cmd_t cmd
);

  import stwq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.frame_in ? ST_CMP : ST_WR;
        end
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

// ----- src/stwq_dp.sv -----
module stwq_dp #(
  parameter int SCENE_COUNT = stwq_pkg::DEF_SCENE_COUNT,
  parameter int LIST_DEPTH  = stwq_pkg::DEF_LIST_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [stwq_pkg::ACTION_W-1:0]        in_action,
  input  logic [stwq_pkg::SCENE_W-1:0]         in_scene,
  input  logic [stwq_pkg::STAMP_W-1:0]         in_stamp_ms,
  output logic [stwq_pkg::COUNT_OUT_W-1:0]     out_list_count,
  output logic                                 out_purged,
  output logic                                 out_duplicate,
  input  logic                                 cfg_we,
  input  logic [stwq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stwq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  stwq_pkg::cmd_t                       cmd,
  output stwq_pkg::sts_t                       sts
);

  import stwq_pkg::*;

  localparam int SC_W  = (SCENE_COUNT > 1) ? $clog2(SCENE_COUNT) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IW    = $clog2(LIST_DEPTH);
  localparam int LW    = ((CNT_W + 1) > LIMIT_W) ? (CNT_W + 1) : LIMIT_W;
  localparam int ROW_W = LIST_DEPTH * STAMP_W;

  typedef logic [LIST_DEPTH-1:0][STAMP_W-1:0] row_t;

  logic [GAP_W-1:0]    gap_r;
  logic [LIMIT_W-1:0]  lim_r;
  logic [ACTION_W-1:0] action_r;
  logic [SCENE_W-1:0]  scene_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic                valid_r;
  logic [CNT_W-1:0]    counts_r [SCENE_COUNT];

  logic [LIST_DEPTH-1:0] lt_r, eq_r;
  logic                  purge_r;
  logic [CNT_W-1:0]      n_r;

  logic [COUNT_OUT_W-1:0] out_cnt_r;
  logic                   out_purged_r, out_dup_r;

  logic              in_scene_ok;
  logic [SC_W-1:0]   scene_idx;
  logic [ROW_W-1:0]  ram_rdata;
  row_t              row, newrow;
  logic [CNT_W-1:0]  cur_count, nm1;
  logic [STAMP_W-1:0] newest, absdiff;
  logic              gap_big;
  logic [LIST_DEPTH-1:0] lt_nxt, eq_nxt, ltm, eqm;

  logic [CNT_W-1:0]   n_eff, n_new;
  logic               dup;
  logic [STAMP_W-1:0] tmp [LIST_DEPTH+1];
  logic [LW-1:0]      n1, lim_eff, drop;
  logic [LW:0]        jsum;

  logic             ram_we, cnt_we, clr_all;
  logic [CNT_W-1:0] cnt_wval;
  logic [CNT_W-1:0] res_cnt;
  logic             res_purged, res_dup;

  assign in_scene_ok  = (32'(in_scene) < 32'(SCENE_COUNT));
  assign sts.frame_in = (in_action == ACT_FRAME) && in_scene_ok;
  assign scene_idx    = SC_W'(scene_r);

  stwq_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SCENE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scene_idx),
    .wdata (newrow),
    .re    (cmd.accept && sts.frame_in),
    .raddr (SC_W'(in_scene)),
    .rdata (ram_rdata)
  );

  assign row = ram_rdata;

  // compare stage
  always_comb begin
    cur_count = valid_r ? counts_r[scene_idx] : '0;
    nm1       = cur_count - CNT_W'(1);
    newest    = row[nm1[IW-1:0]];
    absdiff   = (stamp_r >= newest) ? (stamp_r - newest) : (newest - stamp_r);
    gap_big   = (cur_count != '0) && (absdiff > STAMP_W'(gap_r));
    for (int i = 0; i < LIST_DEPTH; i++) begin
      lt_nxt[i] = row[i] < stamp_r;
      eq_nxt[i] = row[i] == stamp_r;
    end
  end

  // insert and trim
  always_comb begin
    n_eff = purge_r ? '0 : n_r;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ltm[i] = lt_r[i] && (CNT_W'(i) < n_eff);
      eqm[i] = eq_r[i] && (CNT_W'(i) < n_eff);
    end
    dup = |eqm;

    tmp[0] = ltm[0] ? row[0] : stamp_r;
    for (int i = 1; i < LIST_DEPTH; i++) begin
      tmp[i] = ltm[i] ? row[i] : (ltm[i-1] ? stamp_r : row[i-1]);
    end
    tmp[LIST_DEPTH] = ltm[LIST_DEPTH-1] ? stamp_r : row[LIST_DEPTH-1];

    lim_eff = LW'(lim_r);
    if (lim_eff == '0) begin
      lim_eff = LW'(1);
    end else if (lim_eff > LW'(LIST_DEPTH)) begin
      lim_eff = LW'(LIST_DEPTH);
    end
    n1    = LW'(n_eff) + LW'(1);
    drop  = (n1 > lim_eff) ? (n1 - lim_eff) : '0;
    n_new = CNT_W'(n1 - drop);

    jsum = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      jsum      = (LW+1)'(i) + {1'b0, drop};
      newrow[i] = tmp[LIST_DEPTH];
      if (jsum <= (LW+1)'(LIST_DEPTH)) begin
        newrow[i] = tmp[jsum[CNT_W-1:0]];
      end
    end
  end

  // result and state update
  always_comb begin
    ram_we     = 1'b0;
    cnt_we     = 1'b0;
    clr_all    = 1'b0;
    cnt_wval   = '0;
    res_cnt    = '0;
    res_purged = 1'b0;
    res_dup    = 1'b0;
    unique case (action_r)
      ACT_FRAME: begin
        if (valid_r) begin
          res_purged = purge_r;
          res_dup    = dup;
          res_cnt    = dup ? n_eff : n_new;
          cnt_we     = 1'b1;
          cnt_wval   = res_cnt;
          ram_we     = cmd.commit && !dup;
        end
      end
      ACT_CLEAR_ONE: begin
        cnt_we = valid_r;
      end
      ACT_CLEAR_ALL: begin
        clr_all = 1'b1;
      end
      default: begin
        res_cnt = cur_count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
      lim_r <= LIMIT_RESET;
      for (int i = 0; i < SCENE_COUNT; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAP_LIMIT:  gap_r <= cfg_data;
          CFG_SIZE_LIMIT: lim_r <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        if (clr_all) begin
          for (int i = 0; i < SCENE_COUNT; i++) begin
            counts_r[i] <= '0;
          end
        end else if (cnt_we) begin
          counts_r[scene_idx] <= cnt_wval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      scene_r  <= in_scene;
      stamp_r  <= in_stamp_ms;
      valid_r  <= in_scene_ok;
    end
    if (cmd.cmp) begin
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
      purge_r <= gap_big;
      n_r     <= cur_count;
    end
    if (cmd.commit) begin
      out_cnt_r    <= COUNT_OUT_W'(res_cnt);
      out_purged_r <= res_purged;
      out_dup_r    <= res_dup;
    end
  end

  assign out_list_count = out_cnt_r;
  assign out_purged     = out_purged_r;
  assign out_duplicate  = out_dup_r;

endmodule

// ----- src/stwq_checker.sv -----
`include "sorted_timestamp_window_queue_unit_macros.svh"

module stwq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [stwq_pkg::COUNT_OUT_W-1:0] out_list_count,
  input logic                             out_purged,
  input logic                             out_duplicate
);

  // busy right after taking a beat
  `STWQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a purged list cannot also report a duplicate
  `STWQ_ASSERT_IMP(a_purge_not_dup, out_valid && out_purged, !out_duplicate)
  // stalled result holds
  `STWQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_list_count) && $stable(out_purged) && $stable(out_duplicate))

endmodule

bind sorted_timestamp_window_queue_unit stwq_checker u_stwq_checker (.*);
